>>> hdl/grid_two_path_max_sum_dp_macros.svh
// ----------------------------------------------------------------------------
// grid_two_path_max_sum_dp_macros.svh
// Assertion helpers shared by the verification side of the block.
// ----------------------------------------------------------------------------
`ifndef GRID_TWO_PATH_MAX_SUM_DP_MACROS_SVH
`define GRID_TWO_PATH_MAX_SUM_DP_MACROS_SVH

// Property checked only while out of reset.
`define GTPMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define GTPMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/gtpms_pkg.sv
// ----------------------------------------------------------------------------
// gtpms_pkg
// Shared types and constants of the two-path grid maximum-sum engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gtpms_pkg;

  // field widths
  localparam int OPC_W     = 2;
  localparam int ROWCOL_W  = 4;
  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = 14;
  localparam int CFG_W     = 5;
  localparam int GAIN_W    = SAMPLE_W + 1;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [SUM_W-1:0] SUM_LIMIT     = 14'h3FFF;
  localparam logic [CFG_W-1:0] GRID_SIZE_RST = 5'd16;

  // request opcodes
  typedef logic [OPC_W-1:0] opcode_t;
  localparam opcode_t OP_LOAD    = 2'd0;
  localparam opcode_t OP_COMPUTE = 2'd1;
  localparam opcode_t OP_CLEAR   = 2'd2;

  // steps of one position-pair update
  typedef logic [2:0] step_t;
  localparam step_t STEP_P0 = 3'd0;
  localparam step_t STEP_P1 = 3'd1;
  localparam step_t STEP_P2 = 3'd2;
  localparam step_t STEP_P3 = 3'd3;
  localparam step_t STEP_WR = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic  clr_en;
    logic  load_en;
    logic  start;
    logic  init_wr;
    logic  pair_en;
    step_t step;
    logic  fin_rd;
    logic  out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic single;
    logic last_pair;
    logic last_diag;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/gtpms_ram.sv
// ----------------------------------------------------------------------------
// gtpms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/gtpms_ctrl.sv
// ----------------------------------------------------------------------------
// gtpms_ctrl
// Sequencer: request handshake, grid clearing, diagonal sweep, result output.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpms_ctrl import gtpms_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  opcode_t in_opcode,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output cmd_t    cmd,
  input  sts_t    sts
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_PAIR,
    S_FIN_RD,
    S_FIN_CAP
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   in_tready_r, in_tready_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_acc   = in_tvalid && in_tready_r;
  assign out_free = !out_tvalid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    in_tready_nxt  = in_tready_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    cmd.step       = step_r;

    unique case (state_r)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_nxt     = S_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            OP_LOAD: begin
              cmd.load_en = 1'b1;
            end
            OP_COMPUTE: begin
              cmd.start     = 1'b1;
              state_nxt     = S_INIT_RD;
              in_tready_nxt = 1'b0;
            end
            OP_CLEAR: begin
              state_nxt     = S_CLR;
              in_tready_nxt = 1'b0;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      S_INIT_RD: begin
        // cell (0,0) read is the datapath's default address
        state_nxt = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        step_nxt    = STEP_P0;
        state_nxt   = sts.single ? S_FIN_RD : S_PAIR;
      end
      S_PAIR: begin
        cmd.pair_en = 1'b1;
        if (step_r == STEP_WR) begin
          step_nxt = STEP_P0;
          if (sts.last_pair && sts.last_diag) begin
            state_nxt = S_FIN_RD;
          end
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end
      S_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        cmd.fin_rd = 1'b1;
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          in_tready_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      step_r       <= STEP_P0;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

`default_nettype wire

>>> hdl/gtpms_dp.sv
// ----------------------------------------------------------------------------
// gtpms_dp
// Datapath: grid memory, two ping-pong pair tables, diagonal/pair counters and
// the max-plus update of one position pair.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpms_dp import gtpms_pkg::*; #(
  parameter int GRID_MAX = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [ROWCOL_W-1:0] row,
  input  logic [ROWCOL_W-1:0] col,
  input  logic [SAMPLE_W-1:0] sample,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic [SUM_W-1:0]    best_sum
);

  localparam int IDX_W  = $clog2(GRID_MAX);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int T_W    = $clog2(2 * GRID_MAX);
  localparam int N_W    = $clog2(GRID_MAX + 1);
  localparam int CW     = (N_W > CFG_W) ? N_W : CFG_W;
  localparam int RC_W   = (N_W > ROWCOL_W) ? N_W : ROWCOL_W;

  logic [CFG_W-1:0]  grid_size_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [IDX_W-1:0]  n_m1_r;
  logic [T_W-1:0]    t_r;
  logic [IDX_W-1:0]  r1_r, r2_r;
  logic              cur_sel_r;
  logic              pv_r;
  logic [SUM_W-1:0]  mx_r;
  logic [GAIN_W-1:0] g_r;
  logic [SUM_W-1:0]  best_sum_r;

  // grid size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
    end else if (cfg_valid) begin
      grid_size_r <= cfg_data;
    end
  end

  // active side: zero reads as one, large values saturate
  logic [CW-1:0]  gs_ext;
  logic [N_W-1:0] n_act, n_act_m1;
  assign gs_ext   = CW'(grid_size_r);
  assign n_act    = (gs_ext == '0) ? N_W'(1) :
                    (gs_ext > CW'(GRID_MAX)) ? N_W'(GRID_MAX) : N_W'(gs_ext);
  assign n_act_m1 = n_act - N_W'(1);

  // diagonal bounds
  logic [T_W-1:0]   nm1_t, t_inc, lo_cur_t, hi_cur_t, lo_nx_t;
  logic [IDX_W-1:0] lo_cur, hi_cur, lo_nx;
  assign nm1_t    = T_W'(n_m1_r);
  assign t_inc    = t_r + T_W'(1);
  assign lo_cur_t = (t_r > nm1_t) ? (t_r - nm1_t) : '0;
  assign hi_cur_t = (t_r < nm1_t) ? t_r : nm1_t;
  assign lo_nx_t  = (t_inc > nm1_t) ? (t_inc - nm1_t) : '0;
  assign lo_cur   = lo_cur_t[IDX_W-1:0];
  assign hi_cur   = hi_cur_t[IDX_W-1:0];
  assign lo_nx    = lo_nx_t[IDX_W-1:0];

  // columns on the target diagonal
  logic [T_W-1:0]   c1_t, c2_t;
  logic [IDX_W-1:0] c1, c2;
  assign c1_t = t_r - T_W'(r1_r);
  assign c2_t = t_r - T_W'(r2_r);
  assign c1   = c1_t[IDX_W-1:0];
  assign c2   = c2_t[IDX_W-1:0];

  // predecessor on the previous diagonal exists for a move down (row above
  // exists) or a move right (row lies on the previous diagonal too)
  logic up1, up2, st1, st2;
  logic [IDX_W-1:0] r1m, r2m;
  assign up1 = (r1_r != '0);
  assign up2 = (r2_r != '0);
  assign st1 = (T_W'(r1_r) != t_r);
  assign st2 = (T_W'(r2_r) != t_r);
  assign r1m = r1_r - IDX_W'(1);
  assign r2m = r2_r - IDX_W'(1);

  logic [ADDR_W-1:0] pred_addr;
  logic              pred_ok;
  always_comb begin
    case (cmd.step)
      STEP_P0: begin
        pred_addr = {r1m, r2m};
        pred_ok   = up1 && up2;
      end
      STEP_P1: begin
        pred_addr = {r1_r, r2_r};
        pred_ok   = st1 && st2;
      end
      STEP_P2: begin
        pred_addr = {r1_r, r2m};
        pred_ok   = st1 && up2;
      end
      default: begin
        pred_addr = {r1m, r2_r};
        pred_ok   = up1 && st2;
      end
    endcase
  end

  // grid memory: clearing pass, loads, reads of the two visited cells
  logic                cell_we;
  logic [ADDR_W-1:0]   cell_waddr, cell_raddr;
  logic [SAMPLE_W-1:0] cell_wdata, cell_rd;
  logic                row_ok, col_ok;
  assign row_ok     = RC_W'(row) < RC_W'(GRID_MAX);
  assign col_ok     = RC_W'(col) < RC_W'(GRID_MAX);
  assign cell_we    = cmd.clr_en || (cmd.load_en && row_ok && col_ok);
  assign cell_waddr = cmd.clr_en ? clr_addr_r : {IDX_W'(row), IDX_W'(col)};
  assign cell_wdata = cmd.clr_en ? '0 : sample;
  assign cell_raddr = !cmd.pair_en ? '0 :
                      (cmd.step == STEP_P1) ? {r2_r, c2} : {r1_r, c1};

  gtpms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rd)
  );

  // pair tables, current one picked by cur_sel_r
  logic              pair_wr;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] tab_waddr, tab_raddr;
  logic [SUM_W-1:0]  tab_wdata, rd_a, rd_b, tab_rd;
  logic [SUM_W-1:0]  pred_val, mx_upd;
  logic [SUM_W:0]    cand;
  logic [SUM_W-1:0]  cand_sat;

  assign pair_wr   = cmd.pair_en && (cmd.step == STEP_WR);
  assign tab_rd    = cur_sel_r ? rd_b : rd_a;
  assign pred_val  = pv_r ? tab_rd : '0;
  assign mx_upd    = (pred_val > mx_r) ? pred_val : mx_r;
  assign cand      = {1'b0, mx_upd} + (SUM_W + 1)'(g_r);
  assign cand_sat  = (cand > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_LIMIT : cand[SUM_W-1:0];
  assign tab_wdata = cmd.init_wr ? SUM_W'(cell_rd) : cand_sat;
  assign tab_waddr = cmd.init_wr ? '0 : {r1_r, r2_r};
  assign tab_raddr = cmd.fin_rd ? {n_m1_r, n_m1_r} : pred_addr;
  assign we_a      = (cmd.init_wr && !cur_sel_r) || (pair_wr && cur_sel_r);
  assign we_b      = (cmd.init_wr && cur_sel_r) || (pair_wr && !cur_sel_r);

  gtpms_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_tab_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (rd_a)
  );

  gtpms_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_tab_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (rd_b)
  );

  // counters: clear address, diagonal, pair position, table select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      n_m1_r     <= '0;
      t_r        <= '0;
      r1_r       <= '0;
      r2_r       <= '0;
      cur_sel_r  <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cmd.start) begin
        n_m1_r <= n_act_m1[IDX_W-1:0];
      end
      if (cmd.init_wr) begin
        t_r  <= T_W'(1);
        r1_r <= '0;
        r2_r <= '0;
      end else if (pair_wr) begin
        if (r2_r == hi_cur) begin
          if (r1_r == hi_cur) begin
            // diagonal done: next table becomes current
            t_r       <= t_inc;
            r1_r      <= lo_nx;
            r2_r      <= lo_nx;
            cur_sel_r <= !cur_sel_r;
          end else begin
            r1_r <= r1_r + IDX_W'(1);
            r2_r <= lo_cur;
          end
        end else begin
          r2_r <= r2_r + IDX_W'(1);
        end
      end
    end
  end

  // per-pair accumulators
  always_ff @(posedge clk) begin
    if (cmd.pair_en) begin
      pv_r <= pred_ok;
      mx_r <= (cmd.step == STEP_P0) ? '0 : mx_upd;
      if (cmd.step == STEP_P1) begin
        g_r <= GAIN_W'(cell_rd);
      end else if (cmd.step == STEP_P2 && r1_r != r2_r) begin
        g_r <= g_r + GAIN_W'(cell_rd);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      best_sum_r <= tab_rd;
    end
  end

  assign best_sum      = best_sum_r;
  assign sts.clr_done  = (clr_addr_r == '1);
  assign sts.single    = (n_m1_r == '0);
  assign sts.last_pair = (r1_r == hi_cur) && (r2_r == hi_cur);
  assign sts.last_diag = (t_r == (nm1_t << 1));

endmodule

`default_nettype wire

>>> hdl/grid_two_path_max_sum_dp.sv
// ----------------------------------------------------------------------------
// grid_two_path_max_sum_dp
// Two monotone paths over a square grid: best total with shared cells once.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. tuser = opcode (load cell, compute, clear grid);
//           tdata = row, col, sample. Loads are accepted back to back.
//   out_* : one result per compute request, tdata = best_sum.
//   cfg_* : grid side length, always accepted; write it only while idle.
// Compute: side n taken from the register (0 -> 1, capped at GRID_MAX). Cell
//   (0,0) seeds the table, then each position pair (r1, r2) on every
//   anti-diagonal is updated in steps: four reads of the current pair table
//   through its single read port plus the write of the next table.
// Clear request and reset: a sweep zeroes all 2**(2*clog2(GRID_MAX)) grid
//   cells (256 at default) one cell a cycle, with in_tready low.
// A finished result sits in an output register; new requests are taken while
//   it waits. A second compute holds its result until out_tready frees the
//   register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_two_path_max_sum_dp import gtpms_pkg::*; #(
  parameter int GRID_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] row, [7:4] col, [15:8] sample
  input  logic [OPC_W-1:0]      in_tuser,   // [1:0] opcode
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [13:0] best_sum, [15:14] zero
  // grid size register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t             cmd;
  sts_t             sts;
  logic [SUM_W-1:0] best_sum;

  gtpms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  gtpms_dp #(
    .GRID_MAX (GRID_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .row       (in_tdata[3:0]),
    .col       (in_tdata[7:4]),
    .sample    (in_tdata[15:8]),
    .cmd       (cmd),
    .sts       (sts),
    .best_sum  (best_sum)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_DATA_W - SUM_W)'(0), best_sum};

endmodule

`default_nettype wire

>>> hdl/gtpms_chk.sv
// ----------------------------------------------------------------------------
// gtpms_chk
// Port-level checks of the grid two-path engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_two_path_max_sum_dp_macros.svh"

module gtpms_chk import gtpms_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OPC_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_acc;
  logic long_req;
  logic out_stall;

  assign in_acc    = in_tvalid && in_tready;
  assign long_req  = (in_tuser == OP_COMPUTE) || (in_tuser == OP_CLEAR);
  assign out_stall = out_tvalid && !out_tready;

  // reset starts the clearing sweep: nothing accepted, nothing offered
  `GTPMS_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !in_tready && !out_tvalid, "busy after reset")

  // compute and clear requests occupy the engine
  `GTPMS_ASSERT(a_busy, clk, rst_n, in_acc && long_req |=> !in_tready, "ready after long request")

  // a cell load never stalls the request side
  `GTPMS_ASSERT(a_load, clk, rst_n, in_acc && in_tuser == OP_LOAD |=> in_tready, "load stall")

  // a stalled result stays offered
  `GTPMS_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid, "result dropped under stall")

  // a stalled result keeps its data
  `GTPMS_ASSERT(a_out_data, clk, rst_n, out_stall |=> $stable(out_tdata), "result data moved")

endmodule

bind grid_two_path_max_sum_dp gtpms_chk u_chk (.*);

`default_nettype wire
